### rtl/wpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpst_pkg
// Shared widths, command and status codes, and byte-select helpers for the
// watchpoint slot table.
// ----------------------------------------------------------------------------
package wpst_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int ADDR_W    = 64;
  localparam int LEN_W     = 4;
  localparam int BAS_W     = 8;
  localparam int KIND_W    = 2;
  localparam int CMD_W     = 2;
  localparam int TYPE_W    = 2;
  localparam int STAT_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(16);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  localparam logic [TYPE_W-1:0] TYPE_RW    = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_WRITE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_RW    = 2'b11;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'b10;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_TYPE  = 3'd5;

  typedef struct packed {
    logic              ok;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] range_begin;
    logic [LEN_W-1:0]  range_length;
  } result_t;

  function automatic result_t fail_res(input logic [STAT_W-1:0] st);
    result_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // length in bytes encoded by a byte-select mask, zero for odd patterns
  function automatic logic [LEN_W-1:0] bas_length(input logic [BAS_W-1:0] bas);
    logic [LEN_W-1:0] l;
    case (bas)
      8'h01, 8'h02, 8'h04, 8'h08,
      8'h10, 8'h20, 8'h40, 8'h80: l = 4'd1;
      8'h03, 8'h0c, 8'h30, 8'hc0: l = 4'd2;
      8'h0f, 8'hf0:               l = 4'd4;
      8'hff:                      l = 4'd8;
      default:                    l = 4'd0;
    endcase
    return l;
  endfunction

  // size legal, start aligned to size, and word base not zero
  function automatic logic range_ok(input logic [ADDR_W-1:0] addr,
                                    input logic [LEN_W-1:0] len);
    logic al;
    case (len)
      4'd1:    al = 1'b1;
      4'd2:    al = (addr[0] == 1'b0);
      4'd4:    al = (addr[1:0] == 2'b00);
      4'd8:    al = (addr[2:0] == 3'b000);
      default: al = 1'b0;
    endcase
    return al && (addr[ADDR_W-1:2] != '0);
  endfunction

  function automatic logic [BAS_W-1:0] make_bas(input logic [1:0] off,
                                                input logic [LEN_W-1:0] len);
    logic [BAS_W-1:0] b;
    case (len)
      4'd1:    b = 8'b0000_0001 << off;
      4'd2:    b = 8'b0000_0011 << off;
      4'd4:    b = 8'h0f;
      default: b = 8'hff;
    endcase
    return b;
  endfunction

endpackage

### rtl/wpst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpst_if
// Valid/ready channel interfaces for the watchpoint slot table: command in,
// result out, and the active slot count register write.
// ----------------------------------------------------------------------------
interface wpst_in_if;
  logic                         valid;
  logic                         ready;
  logic [wpst_pkg::CMD_W-1:0]   command;
  logic [wpst_pkg::ADDR_W-1:0]  address;
  logic [wpst_pkg::LEN_W-1:0]   length;
  logic [wpst_pkg::TYPE_W-1:0]  access_type;

  modport source(output valid, command, address, length, access_type, input ready);
  modport sink(input valid, command, address, length, access_type, output ready);
endinterface

interface wpst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [wpst_pkg::STAT_W-1:0]  status;
  logic [wpst_pkg::SLOT_W-1:0]  slot;
  logic [wpst_pkg::ADDR_W-1:0]  range_begin;
  logic [wpst_pkg::LEN_W-1:0]   range_length;

  modport source(output valid, ok, status, slot, range_begin, range_length, input ready);
  modport sink(input valid, ok, status, slot, range_begin, range_length, output ready);
endinterface

interface wpst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wpst_pkg::CNT_W-1:0]   data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/watchpoint_slot_table.sv
`timescale 1ns / 1ps
// Sequence: accept in S_IDLE, scan n = min(active_slots, NUM_SLOTS) slots in
// S_SCAN, then load the output register from S_DONE once it is free; a command
// that fails its checks or searches no slot skips S_SCAN; the next is taken only
// in S_IDLE. Add stops at a free slot or duplicate, remove or decode at a hit.
// Reset: synchronous active-low; all slots free, active_slots = 16.
// ----------------------------------------------------------------------------
// watchpoint_slot_table
// Watchpoint slot allocator: add, remove and decode over a synchronous slot
// memory with per-slot valid bits, scanned one entry per cycle.
// ----------------------------------------------------------------------------
module watchpoint_slot_table #(
  parameter int NUM_SLOTS = wpst_pkg::MAX_SLOTS
) (
  input logic        clk,
  input logic        rst_n,
  wpst_in_if.sink    in_if,
  wpst_out_if.source out_if,
  wpst_cfg_if.sink   cfg_if
);
  import wpst_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENT_W = 1 + KIND_W + BAS_W + ADDR_W;
  localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // slot memory: {enable, kind, bas, base}; valid_r marks slots in use
  logic [ENT_W-1:0]     mem [NUM_SLOTS];
  logic [ENT_W-1:0]     rd_data_r;
  logic                 rd_vld_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [ENT_W-1:0]     mem_wd;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  active_r, active_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [BAS_W-1:0]  bas_r, bas_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [ADDR_W-1:0] best_base_r, best_base_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  // read side of the current entry
  logic              ent_en;
  logic [BAS_W-1:0]  ent_bas;
  logic [ADDR_W-1:0] ent_addr;
  logic [LEN_W-1:0]  ent_len;
  logic [ADDR_W-1:0] base;
  logic              hit_eq;
  logic              last;
  logic              live;
  logic              borrow;
  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] gap;
  logic              in_rng;
  logic [CNT_W-1:0]  cnt_in;
  logic              issue;
  logic [IDX_W-1:0]  rd_idx;

  assign ent_en   = rd_data_r[ENT_W-1];
  assign ent_bas  = rd_data_r[ADDR_W +: BAS_W];
  assign ent_addr = rd_data_r[ADDR_W-1:0];
  assign ent_len  = bas_length(ent_bas);
  assign base     = {addr_r[ADDR_W-1:2], 2'b00};
  assign hit_eq   = rd_vld_r && (ent_addr == base) && (ent_len == len_r);
  assign last     = ((CNT_W'(chk_idx_r) + CNT_W'(1)) == n_r);
  assign live     = rd_vld_r && ent_en && (ent_len != '0);
  assign {borrow, diff} = {1'b0, addr_r} - {1'b0, ent_addr};
  assign in_rng   = !borrow && (diff < ADDR_W'(ent_len));
  assign gap      = borrow ? (ent_addr - addr_r) : (diff - ADDR_W'(ent_len));
  assign cnt_in   = (active_r > NUM_CNT) ? NUM_CNT : active_r;
  assign issue    = (state_r == S_SCAN) && (rd_cnt_r < n_r);
  assign rd_idx   = rd_cnt_r[IDX_W-1:0];

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid        = out_vld_r;
  assign out_if.ok           = out_r.ok;
  assign out_if.status       = out_r.status;
  assign out_if.slot         = out_r.slot;
  assign out_if.range_begin  = out_r.range_begin;
  assign out_if.range_length = out_r.range_length;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    kind_nxt      = kind_r;
    bas_nxt       = bas_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    chk_vld_nxt   = issue;
    chk_idx_nxt   = rd_idx;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_base_nxt = best_base_r;
    best_len_nxt  = best_len_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !out_if.ready;
    valid_nxt     = valid_r;
    mem_we        = 1'b0;
    mem_wa        = chk_idx_r;
    mem_wd        = {1'b1, kind_r, bas_r, base};

    if (cfg_if.valid) begin
      active_nxt = cfg_if.data;
    end

    if (issue) begin
      rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt    = in_if.command;
          addr_nxt   = in_if.address;
          len_nxt    = in_if.length;
          kind_nxt   = (in_if.access_type == TYPE_RW) ? KIND_RW : KIND_WRITE;
          bas_nxt    = make_bas(in_if.address[1:0], in_if.length);
          n_nxt      = cnt_in;
          rd_cnt_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_DONE;
          case (in_if.command)
            CMD_ADD: begin
              if (in_if.access_type != TYPE_RW && in_if.access_type != TYPE_WRITE) begin
                res_nxt = fail_res(ST_BAD_TYPE);
              end else if (!range_ok(in_if.address, in_if.length)) begin
                res_nxt = fail_res(ST_BAD_RANGE);
              end else if (cnt_in == '0) begin
                res_nxt = fail_res(ST_FULL);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (!range_ok(in_if.address, in_if.length)) begin
                res_nxt = fail_res(ST_BAD_RANGE);
              end else if (cnt_in == '0) begin
                res_nxt = fail_res(ST_NOT_FOUND);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_DECODE: begin
              if (cnt_in == '0) begin
                res_nxt = fail_res(ST_NOT_FOUND);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt = fail_res(ST_BAD_TYPE);
            end
          endcase
        end
      end

      S_SCAN: begin
        if (chk_vld_r) begin
          case (cmd_r)
            CMD_ADD: begin
              if (!rd_vld_r) begin
                // first free slot: claim it
                mem_we               = 1'b1;
                valid_nxt[chk_idx_r] = 1'b1;
                res_nxt              = '{ok: 1'b1, status: ST_OK,
                                         slot: SLOT_W'(chk_idx_r),
                                         range_begin: addr_r, range_length: len_r};
                state_nxt            = S_DONE;
              end else if (hit_eq) begin
                res_nxt   = fail_res(ST_DUPLICATE);
                state_nxt = S_DONE;
              end else if (last) begin
                res_nxt   = fail_res(ST_FULL);
                state_nxt = S_DONE;
              end
            end
            CMD_REMOVE: begin
              if (hit_eq) begin
                valid_nxt[chk_idx_r] = 1'b0;
                res_nxt              = fail_res(ST_OK);
                res_nxt.ok           = 1'b1;
                res_nxt.slot         = SLOT_W'(chk_idx_r);
                state_nxt            = S_DONE;
              end else if (last) begin
                res_nxt   = fail_res(ST_NOT_FOUND);
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (live && in_rng) begin
                res_nxt   = '{ok: 1'b1, status: ST_OK, slot: SLOT_W'(chk_idx_r),
                              range_begin: ent_addr, range_length: ent_len};
                state_nxt = S_DONE;
              end else begin
                // nearest slot so far; ties keep the earlier one
                if (live && (!found_r || gap < best_r)) begin
                  found_nxt     = 1'b1;
                  best_nxt      = gap;
                  best_idx_nxt  = chk_idx_r;
                  best_base_nxt = ent_addr;
                  best_len_nxt  = ent_len;
                end
                if (last) begin
                  state_nxt = S_DONE;
                  if (found_nxt) begin
                    res_nxt = '{ok: 1'b1, status: ST_OK, slot: SLOT_W'(best_idx_nxt),
                                range_begin: best_base_nxt, range_length: best_len_nxt};
                  end else begin
                    res_nxt = fail_res(ST_NOT_FOUND);
                  end
                end
              end
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_if.ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= ACTIVE_RESET;
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      found_r   <= 1'b0;
      rd_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      valid_r   <= valid_nxt;
      rd_vld_r  <= valid_r[rd_idx];
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
      found_r   <= found_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    len_r       <= len_nxt;
    kind_r      <= kind_nxt;
    bas_r       <= bas_nxt;
    n_r         <= n_nxt;
    chk_idx_r   <= chk_idx_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    best_base_r <= best_base_nxt;
    best_len_r  <= best_len_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule

### bench/watchpoint_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchpoint_slot_table_tb
// Self-checking bench for the watchpoint slot table. A clocked driver feeds
// add, remove and decode commands from a queue; a clocked monitor keeps its
// own copy of the slot table, predicts every answer and compares each result
// field by field. Runs a directed opening, then random phases over several
// active slot counts with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module watchpoint_slot_table_tb;
  import wpst_pkg::*;

  localparam int NUM_SLOTS   = MAX_SLOTS;
  localparam int HALF_PERIOD = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = NUM_SLOTS + 8;
  localparam int PHASE_ITEMS = 60;
  localparam int POOL_SIZE   = 20;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [TYPE_W-1:0] TYPE_RSVD2 = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_RSVD3 = 2'd3;

  // idle patterns
  localparam int MODE_NONE   = 0;
  localparam int MODE_SENDER = 1;
  localparam int MODE_RECV   = 2;
  localparam int MODE_BOTH   = 3;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [TYPE_W-1:0] access_type;
    bit                drain_first;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wpst_in_if  in_ch ();
  wpst_out_if out_ch ();
  wpst_cfg_if cfg_ch ();

  watchpoint_slot_table #(.NUM_SLOTS(NUM_SLOTS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow copy of the slot table
  logic [ADDR_W-1:0] slot_base [NUM_SLOTS];
  logic [BAS_W-1:0]  slot_mask [NUM_SLOTS];
  logic [KIND_W-1:0] slot_kind [NUM_SLOTS];
  logic              slot_on   [NUM_SLOTS];
  logic [CNT_W-1:0]  active_count;

  cmd_item_t   cmds_to_send [$];
  result_t     answers_due [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  int  idle_mode = MODE_NONE;
  int  mismatches = 0;
  int  cfg_writes = 0;
  int  idle_cycles = 0;
  logic in_taken = 1'b0;

  // bytes covered by a byte-select mask: an aligned run of 1, 2, 4 or 8 ones
  function automatic logic [LEN_W-1:0] mask_bytes(input logic [BAS_W-1:0] m);
    logic [LEN_W-1:0] s;
    s = '0;
    for (int w = 1; w <= 8; w = w * 2)
      for (int k = 0; k < 8 / w; k++)
        if (m == 8'(((1 << w) - 1) << (k * w))) s = LEN_W'(w);
    return s;
  endfunction

  function automatic bit range_legal(input logic [ADDR_W-1:0] a,
                                     input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    m = ADDR_W'(len) - 64'd1;
    return (len == 4'd1 || len == 4'd2 || len == 4'd4 || len == 4'd8) &&
           ((a & m) == '0) && (a[ADDR_W-1:2] != '0);
  endfunction

  // updates the shadow table and returns the answer the block must give
  function automatic result_t apply_command(input cmd_item_t c);
    result_t r;
    int n, i, pick;
    logic [ADDR_W-1:0] base, gap, best;
    logic [LEN_W-1:0] w;
    bit stop, dup;
    r = '0;
    pick = -1;
    stop = 0;
    dup = 0;
    best = '0;
    n = (active_count > NUM_SLOTS) ? NUM_SLOTS : int'(active_count);
    base = {c.address[ADDR_W-1:2], 2'b00};
    case (c.command)
      CMD_ADD: begin
        if (c.access_type != TYPE_RW && c.access_type != TYPE_WRITE) begin
          r.status = ST_BAD_TYPE;
        end else if (!range_legal(c.address, c.length)) begin
          r.status = ST_BAD_RANGE;
        end else begin
          // duplicates only count ahead of the first free slot
          for (i = 0; i < n && !stop; i++) begin
            if (slot_base[i] == '0) begin
              pick = i;
              stop = 1;
            end else if (slot_base[i] == base && mask_bytes(slot_mask[i]) == c.length) begin
              dup = 1;
              stop = 1;
            end
          end
          if (dup) begin
            r.status = ST_DUPLICATE;
          end else if (pick < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_base[pick] = base;
            case (c.length)
              4'd1:    slot_mask[pick] = 8'h01 << c.address[1:0];
              4'd2:    slot_mask[pick] = 8'h03 << c.address[1:0];
              4'd4:    slot_mask[pick] = 8'h0f;
              default: slot_mask[pick] = 8'hff;
            endcase
            slot_kind[pick] = (c.access_type == TYPE_RW) ? KIND_RW : KIND_WRITE;
            slot_on[pick] = 1'b1;
            r.ok = 1'b1;
            r.status = ST_OK;
            r.slot = SLOT_W'(pick);
            r.range_begin = c.address;
            r.range_length = c.length;
          end
        end
      end
      CMD_REMOVE: begin
        if (!range_legal(c.address, c.length)) begin
          r.status = ST_BAD_RANGE;
        end else begin
          for (i = 0; i < n && !stop; i++) begin
            if (slot_base[i] != '0 && slot_base[i] == base &&
                mask_bytes(slot_mask[i]) == c.length) begin
              pick = i;
              stop = 1;
            end
          end
          if (pick < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            slot_base[pick] = '0;
            slot_mask[pick] = '0;
            slot_kind[pick] = '0;
            slot_on[pick] = 1'b0;
            r.ok = 1'b1;
            r.slot = SLOT_W'(pick);
          end
        end
      end
      CMD_DECODE: begin
        // first containing slot wins outright, else the first nearest one
        for (i = 0; i < n && !stop; i++) begin
          w = mask_bytes(slot_mask[i]);
          if (slot_on[i] && w != '0) begin
            if (c.address >= slot_base[i] && c.address - slot_base[i] < ADDR_W'(w)) begin
              pick = i;
              stop = 1;
            end else begin
              gap = (c.address < slot_base[i]) ? slot_base[i] - c.address
                                               : c.address - slot_base[i] - ADDR_W'(w);
              if (pick < 0 || gap < best) begin
                pick = i;
                best = gap;
              end
            end
          end
        end
        if (pick < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.ok = 1'b1;
          r.slot = SLOT_W'(pick);
          r.range_begin = slot_base[pick];
          r.range_length = mask_bytes(slot_mask[pick]);
        end
      end
      default: r.status = ST_BAD_TYPE;
    endcase
    return r;
  endfunction

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // mostly well-formed commands on a small address pool, some raw noise
  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int sel;
    logic [ADDR_W-1:0] base;
    sel = $urandom_range(0, 99);
    base = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    c.drain_first = 0;
    if (sel < 8) begin
      c.command = CMD_W'($urandom_range(0, 3));
      c.address = {$urandom, $urandom};
      c.length = LEN_W'($urandom_range(0, 15));
      c.access_type = TYPE_W'($urandom_range(0, 3));
    end else begin
      if (sel < 50) c.command = CMD_ADD;
      else if (sel < 72) c.command = CMD_REMOVE;
      else c.command = CMD_DECODE;
      c.length = LEN_W'(1 << $urandom_range(0, 3));
      c.access_type = coin(50) ? TYPE_RW : TYPE_WRITE;
      case (c.length)
        4'd1:    c.address = base + ADDR_W'($urandom_range(0, 3));
        4'd2:    c.address = base + ADDR_W'(2 * $urandom_range(0, 1));
        default: c.address = base;
      endcase
      if (c.command == CMD_DECODE) c.address = base + ADDR_W'($urandom_range(0, 23)) - 64'd8;
    end
    return c;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                           input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] ty);
    cmd_item_t c;
    c.command = cmd;
    c.address = a;
    c.length = len;
    c.access_type = ty;
    c.drain_first = 0;
    cmds_to_send.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmds_to_send.size() != 0 || answers_due.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active(input logic [CNT_W-1:0] v);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_ch.valid <= 1'b0;
  endtask

  // command driver
  always @(negedge clk) begin : drive_cmds
    cmd_item_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (cmds_to_send.size() != 0 &&
          !(cmds_to_send[0].drain_first && answers_due.size() != 0) &&
          !((idle_mode == MODE_SENDER && coin(77)) || (idle_mode == MODE_BOTH && coin(8)))) begin
        c = cmds_to_send.pop_front();
        in_ch.command <= c.command;
        in_ch.address <= c.address;
        in_ch.length <= c.length;
        in_ch.access_type <= c.access_type;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    out_ch.ready <= !((idle_mode == MODE_RECV && coin(77)) || (idle_mode == MODE_BOTH && coin(8)));
  end

  // monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin : check_results
    result_t want, got;
    cmd_item_t c;
    bit moved;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_base[i] = '0;
        slot_mask[i] = '0;
        slot_kind[i] = '0;
        slot_on[i] = 1'b0;
      end
      active_count = ACTIVE_RESET;
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      moved = 0;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1;
        got.ok = out_ch.ok;
        got.status = out_ch.status;
        got.slot = out_ch.slot;
        got.range_begin = out_ch.range_begin;
        got.range_length = out_ch.range_length;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, actual ok %0d status %0d slot %0d", $time,
                   got.ok, got.status, got.slot);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok: expected %0d, actual %0d", $time, want.ok, got.ok);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status: expected %0d, actual %0d", $time, want.status, got.status);
            mismatches++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot: expected %0d, actual %0d", $time, want.slot, got.slot);
            mismatches++;
          end
          if (got.range_begin !== want.range_begin) begin
            $display("%0t: range_begin: expected %h, actual %h", $time,
                     want.range_begin, got.range_begin);
            mismatches++;
          end
          if (got.range_length !== want.range_length) begin
            $display("%0t: range_length: expected %0d, actual %0d", $time,
                     want.range_length, got.range_length);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1;
        c.command = in_ch.command;
        c.address = in_ch.address;
        c.length = in_ch.length;
        c.access_type = in_ch.access_type;
        c.drain_first = 0;
        answers_due.push_back(apply_command(c));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1;
        active_count = cfg_ch.data;
        cfg_writes++;
      end
      in_taken <= in_ch.valid && in_ch.ready;
      if (moved) begin
        idle_cycles = 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("watchpoint_slot_table test failed");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin : stimulus
    cmd_item_t c;
    logic [CNT_W-1:0] v;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.address = '0;
    in_ch.length = '0;
    in_ch.access_type = TYPE_RW;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;

    addr_pool[0] = 64'h8;
    addr_pool[1] = 64'hffff_ffff_ffff_fff8;
    addr_pool[2] = {$urandom, $urandom} & ~64'h7;
    for (int i = 3; i < POOL_SIZE; i++) begin
      // a cluster near one base so decode has close neighbors, then spread
      addr_pool[i] = (i < 10) ? addr_pool[2] + ADDR_W'(16 * i) : {$urandom, $urandom} & ~64'h7;
      if (addr_pool[i][ADDR_W-1:3] == '0) addr_pool[i] = 64'h10;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: checks, placement, duplicates, decode, remove, odd command
    queue_cmd(CMD_ADD, 64'h1000, 4'd4, TYPE_RSVD2);
    queue_cmd(CMD_ADD, 64'h1000, 4'd8, TYPE_RSVD3);
    queue_cmd(CMD_ADD, 64'h1000, 4'd0, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1000, 4'd15, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1000, 4'd3, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1002, 4'd4, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1004, 4'd8, TYPE_WRITE);
    queue_cmd(CMD_ADD, 64'h1001, 4'd2, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h3, 4'd1, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1000, 4'd4, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h1000, 4'd4, TYPE_WRITE);
    queue_cmd(CMD_ADD, 64'h1003, 4'd1, TYPE_WRITE);
    queue_cmd(CMD_ADD, 64'hffff_ffff_ffff_fff8, 4'd8, TYPE_RW);
    queue_cmd(CMD_ADD, 64'h2002, 4'd2, TYPE_WRITE);
    queue_cmd(CMD_DECODE, 64'h1002, 4'd0, TYPE_RW);
    queue_cmd(CMD_DECODE, 64'hffff_ffff_ffff_ffff, 4'd0, TYPE_RW);
    queue_cmd(CMD_DECODE, 64'h0, 4'd0, TYPE_RW);
    queue_cmd(CMD_DECODE, 64'h2100, 4'd0, TYPE_RW);
    queue_cmd(CMD_REMOVE, 64'h1000, 4'd4, TYPE_RSVD3);
    queue_cmd(CMD_REMOVE, 64'h1000, 4'd4, TYPE_RW);
    // freed slot 0 sits ahead of the same range in slot 1: no duplicate
    queue_cmd(CMD_ADD, 64'h1003, 4'd1, TYPE_RW);
    queue_cmd(CMD_REMOVE, 64'h1000, 4'd5, TYPE_RW);
    queue_cmd(CMD_UNUSED, 64'hffff_ffff_ffff_ffff, 4'd15, TYPE_RSVD3);
    wait_idle();
    // no slots searched
    write_active(5'd0);
    queue_cmd(CMD_ADD, 64'h4000, 4'd4, TYPE_RW);
    queue_cmd(CMD_DECODE, 64'h1000, 4'd0, TYPE_RW);
    queue_cmd(CMD_REMOVE, 64'h1000, 4'd1, TYPE_RW);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: v = 5'd16;
        1: v = 5'd4;
        2: v = 5'd1;
        3: v = 5'd0;
        4: v = 5'd31;
        5: v = 5'd9;
        6: v = 5'd16;
        default: v = 5'd2;
      endcase
      write_active(v);
      idle_mode = p % 4;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        c = random_cmd();
        c.drain_first = (k % 40 == 39);
        cmds_to_send.push_back(c);
      end
    end

    wait_idle();
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("watchpoint_slot_table test passed");
    end else begin
      $display("watchpoint_slot_table test failed");
    end
    $finish;
  end

endmodule
